@@ rtl/tlfc_pkg.sv @@
// tlfc_pkg: shared types, constants and helpers for the tabu list frequency check unit
// no dependencies; used by every file under rtl but tlfc_checker, and by tb

package tlfc_pkg;

   localparam int COURSES_DEF = 64;
   localparam int ROOMS_DEF   = 16;
   localparam int DAYS_DEF    = 8;
   localparam int SLOTS_DEF   = 8;

   localparam int TIME_W  = 32;
   localparam int COUNT_W = 16;
   localparam int ENTRY_W = TIME_W + COUNT_W;

   // widest field widths of course (non-negative part), room, day and slot
   localparam int COURSE_FIELD_W = 6;
   localparam int ROOM_FIELD_W   = 4;
   localparam int DAY_FIELD_W    = 3;
   localparam int SLOT_FIELD_W   = 3;

   localparam logic [15:0] TENURE_RESET = 16'd120;
   localparam logic [15:0] COEFF_RESET  = 16'd0;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam logic OP_QUERY = 1'b0;
   localparam logic OP_BAN   = 1'b1;

   localparam logic REG_TENURE = 1'b0;
   localparam logic REG_COEFF  = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_MUL,
      ST_CMP,
      ST_DONE,
      ST_WR1,
      ST_WR2
   } state_type;

   typedef struct packed {
      logic               hit;
      logic [TIME_W-1:0]  stamp;
      logic [COUNT_W-1:0] count;
   } lane_in_type;

   function automatic int clip_width(input int n, input int hi);
      int w;
      w = $clog2(n);
      if (w < 1) w = 1;
      if (w > hi) w = hi;
      return w;
   endfunction

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
      logic [COUNT_W-1:0] r;
      r = (c == COUNT_MAX) ? c : c + COUNT_W'(1);
      return r;
   endfunction

endpackage

@@ rtl/tlfc_store.sv @@
// tlfc_store: tabu entry memory, one write port and two registered read ports
// depends on tlfc_pkg

module tlfc_store #(
   parameter int AW = 16
) (
   input  logic                        clock,
   input  logic                        we,
   input  logic [AW-1:0]               waddr,
   input  logic [tlfc_pkg::ENTRY_W-1:0] wdata,
   input  logic                        re,
   input  logic [AW-1:0]               raddr_a,
   input  logic [AW-1:0]               raddr_b,
   output logic [tlfc_pkg::ENTRY_W-1:0] rdata_a,
   output logic [tlfc_pkg::ENTRY_W-1:0] rdata_b
);

   logic [tlfc_pkg::ENTRY_W-1:0] mem_ff [2**AW];
   logic [tlfc_pkg::ENTRY_W-1:0] rdata_a_ff;
   logic [tlfc_pkg::ENTRY_W-1:0] rdata_b_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_a_ff <= mem_ff[raddr_a];
         rdata_b_ff <= mem_ff[raddr_b];
      end
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule

@@ rtl/tlfc_lane.sv @@
// tlfc_lane: release check for one half of a swap move, multiply then add and compare
// depends on tlfc_pkg

module tlfc_lane (
   input  logic                        clock,
   input  tlfc_pkg::lane_in_type       lane_in,
   input  logic [15:0]                 tenure,
   input  logic [15:0]                 coeff,
   input  logic [tlfc_pkg::TIME_W-1:0] now,
   output logic                        ok
);

   logic [31:0]                 prod_ff;
   logic [tlfc_pkg::TIME_W-1:0] stamp_ff;
   logic                        skip_ff;
   logic                        ok_ff;
   logic [32:0]                 release_val;

   // stage one: penalty product
   always_ff @(posedge clock) begin
      prod_ff  <= 32'(coeff) * 32'(lane_in.count);
      stamp_ff <= lane_in.stamp;
      skip_ff  <= !lane_in.hit || (lane_in.count == '0);
   end

   // stage two: release time against current iteration
   assign release_val = {1'b0, stamp_ff} + 33'(tenure) + 33'(prod_ff[31:8]);

   always_ff @(posedge clock) begin
      ok_ff <= skip_ff || (release_val < {1'b0, now});
   end

   assign ok = ok_ff;

endmodule

@@ rtl/tabu_list_frequency_check_unit.sv @@
// tabu_list_frequency_check_unit: top level, control sequencer, two check lanes and merge
// depends on tlfc_pkg, tlfc_store, tlfc_lane
//
// channel  | direction | handshake               | payload
// req      | in        | req_valid / req_ready   | operation, iteration, courses, rooms, days, slots
// rsp      | out       | rsp_valid / rsp_ready   | allowed (queries only)
// csr      | in/out    | psel, penable, pwrite   | paddr, pwdata, prdata, pready
//
// a query runs these steps between its acceptance and the next acceptance:
// read both entries, multiply, add and compare in both lanes, merge into the output register
// a ban reads both entries, then makes one write per half through the single write port
// after reset the store is cleared one entry a cycle, 2**(address bits) entries (65536 by default)
// a finished result waits in the output register; only the merge step stalls behind it

module tabu_list_frequency_check_unit #(
   parameter int COURSES = tlfc_pkg::COURSES_DEF,
   parameter int ROOMS   = tlfc_pkg::ROOMS_DEF,
   parameter int DAYS    = tlfc_pkg::DAYS_DEF,
   parameter int SLOTS   = tlfc_pkg::SLOTS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_operation,
   input  logic        [31:0] req_iteration,
   input  logic signed [6:0]  req_course_one,
   input  logic        [3:0]  req_room_one,
   input  logic        [2:0]  req_day_one,
   input  logic        [2:0]  req_slot_one,
   input  logic signed [6:0]  req_course_two,
   input  logic        [3:0]  req_room_two,
   input  logic        [2:0]  req_day_two,
   input  logic        [2:0]  req_slot_two,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_allowed,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic        [2:0]  paddr,
   input  logic        [31:0] pwdata,
   output logic        [31:0] prdata,
   output logic               pready
);

   localparam int CW = tlfc_pkg::clip_width(COURSES, tlfc_pkg::COURSE_FIELD_W);
   localparam int RW = tlfc_pkg::clip_width(ROOMS, tlfc_pkg::ROOM_FIELD_W);
   localparam int DW = tlfc_pkg::clip_width(DAYS, tlfc_pkg::DAY_FIELD_W);
   localparam int SW = tlfc_pkg::clip_width(SLOTS, tlfc_pkg::SLOT_FIELD_W);
   localparam int AW = CW + RW + DW + SW;

   tlfc_pkg::state_type state_ff, state_in;

   logic [15:0]   tenure_ff, coeff_ff;
   logic          op_ff;
   logic [31:0]   now_ff;
   logic          hit_a_ff, hit_b_ff, hit_a_in, hit_b_in;
   logic [AW-1:0] addr_a_ff, addr_b_ff, addr_a_in, addr_b_in;
   logic [AW-1:0] clr_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_allowed_ff;

   logic          accept;
   logic          csr_write;
   logic          merge_load;
   logic [3:0]    room_a;
   logic [2:0]    day_a, slot_a;
   logic [3:0]    room_b;
   logic [2:0]    day_b, slot_b;

   logic                          mem_we, mem_re;
   logic [AW-1:0]                 mem_waddr;
   logic [tlfc_pkg::ENTRY_W-1:0]  mem_wdata;
   logic [tlfc_pkg::ENTRY_W-1:0]  rd_a, rd_b;
   logic [tlfc_pkg::COUNT_W-1:0]  cnt_a_new, cnt_b_base;
   tlfc_pkg::lane_in_type         lane_a_in, lane_b_in;
   logic                          ok_a, ok_b;

   assign accept    = req_valid && req_ready;
   assign csr_write = psel && penable && pwrite && pready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tenure_ff <= tlfc_pkg::TENURE_RESET;
         coeff_ff  <= tlfc_pkg::COEFF_RESET;
      end else if (csr_write) begin
         if (paddr[2] == tlfc_pkg::REG_COEFF) begin
            coeff_ff <= pwdata[15:0];
         end else begin
            tenure_ff <= pwdata[15:0];
         end
      end
   end

   assign prdata = (paddr[2] == tlfc_pkg::REG_COEFF) ? {16'd0, coeff_ff} : {16'd0, tenure_ff};
   assign pready = 1'b1;

   // entry location of both halves; a query crosses the assignments, a ban does not
   always_comb begin
      if (req_operation == tlfc_pkg::OP_BAN) begin
         room_a = req_room_one;
         day_a  = req_day_one;
         slot_a = req_slot_one;
         room_b = req_room_two;
         day_b  = req_day_two;
         slot_b = req_slot_two;
      end else begin
         room_a = req_room_two;
         day_a  = req_day_two;
         slot_a = req_slot_two;
         room_b = req_room_one;
         day_b  = req_day_one;
         slot_b = req_slot_one;
      end
      hit_a_in = !req_course_one[6]
                 && (32'(req_course_one[5:0]) < COURSES)
                 && (32'(room_a) < ROOMS) && (32'(day_a) < DAYS) && (32'(slot_a) < SLOTS);
      hit_b_in = !req_course_two[6]
                 && (32'(req_course_two[5:0]) < COURSES)
                 && (32'(room_b) < ROOMS) && (32'(day_b) < DAYS) && (32'(slot_b) < SLOTS);
      addr_a_in = {req_course_one[CW-1:0], room_a[RW-1:0], day_a[DW-1:0], slot_a[SW-1:0]};
      addr_b_in = {req_course_two[CW-1:0], room_b[RW-1:0], day_b[DW-1:0], slot_b[SW-1:0]};
   end

   // item registers
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= req_operation;
         now_ff    <= req_iteration;
         hit_a_ff  <= hit_a_in;
         hit_b_ff  <= hit_b_in;
         addr_a_ff <= addr_a_in;
         addr_b_ff <= addr_b_in;
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tlfc_pkg::ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == tlfc_pkg::ST_CLEAR) begin
            clr_ff <= clr_ff + AW'(1);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tlfc_pkg::ST_CLEAR: begin
            if (clr_ff == '1) state_in = tlfc_pkg::ST_IDLE;
         end
         tlfc_pkg::ST_IDLE: begin
            if (accept) state_in = tlfc_pkg::ST_READ;
         end
         tlfc_pkg::ST_READ: begin
            state_in = (op_ff == tlfc_pkg::OP_BAN) ? tlfc_pkg::ST_WR1 : tlfc_pkg::ST_MUL;
         end
         tlfc_pkg::ST_MUL:  state_in = tlfc_pkg::ST_CMP;
         tlfc_pkg::ST_CMP:  state_in = tlfc_pkg::ST_DONE;
         tlfc_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) state_in = tlfc_pkg::ST_IDLE;
         end
         tlfc_pkg::ST_WR1:  state_in = tlfc_pkg::ST_WR2;
         tlfc_pkg::ST_WR2:  state_in = tlfc_pkg::ST_IDLE;
         default:           state_in = tlfc_pkg::ST_IDLE;
      endcase
   end

   // count updates; same entry in both halves of a ban counts twice
   assign cnt_a_new  = tlfc_pkg::sat_inc(rd_a[tlfc_pkg::COUNT_W-1:0]);
   assign cnt_b_base = (hit_a_ff && (addr_a_ff == addr_b_ff)) ? cnt_a_new
                                                              : rd_b[tlfc_pkg::COUNT_W-1:0];

   always_comb begin
      req_ready  = 1'b0;
      mem_re     = 1'b0;
      mem_we     = 1'b0;
      mem_waddr  = clr_ff;
      mem_wdata  = '0;
      merge_load = 1'b0;
      case (state_ff)
         tlfc_pkg::ST_CLEAR: begin
            mem_we = 1'b1;
         end
         tlfc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
         end
         tlfc_pkg::ST_READ: begin
            mem_re = 1'b1;
         end
         tlfc_pkg::ST_DONE: begin
            merge_load = !rsp_valid_ff || rsp_ready;
         end
         tlfc_pkg::ST_WR1: begin
            mem_we    = hit_a_ff;
            mem_waddr = addr_a_ff;
            mem_wdata = {now_ff, cnt_a_new};
         end
         tlfc_pkg::ST_WR2: begin
            mem_we    = hit_b_ff;
            mem_waddr = addr_b_ff;
            mem_wdata = {now_ff, tlfc_pkg::sat_inc(cnt_b_base)};
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   tlfc_store #(
      .AW (AW)
   ) u_store (
      .clock   (clock),
      .we      (mem_we),
      .waddr   (mem_waddr),
      .wdata   (mem_wdata),
      .re      (mem_re),
      .raddr_a (addr_a_ff),
      .raddr_b (addr_b_ff),
      .rdata_a (rd_a),
      .rdata_b (rd_b)
   );

   assign lane_a_in = '{hit: hit_a_ff, stamp: rd_a[tlfc_pkg::ENTRY_W-1:tlfc_pkg::COUNT_W],
                        count: rd_a[tlfc_pkg::COUNT_W-1:0]};
   assign lane_b_in = '{hit: hit_b_ff, stamp: rd_b[tlfc_pkg::ENTRY_W-1:tlfc_pkg::COUNT_W],
                        count: rd_b[tlfc_pkg::COUNT_W-1:0]};

   tlfc_lane u_lane_a (
      .clock   (clock),
      .lane_in (lane_a_in),
      .tenure  (tenure_ff),
      .coeff   (coeff_ff),
      .now     (now_ff),
      .ok      (ok_a)
   );

   tlfc_lane u_lane_b (
      .clock   (clock),
      .lane_in (lane_b_in),
      .tenure  (tenure_ff),
      .coeff   (coeff_ff),
      .now     (now_ff),
      .ok      (ok_b)
   );

   // merge and output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (merge_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (merge_load) begin
         rsp_allowed_ff <= ok_a && ok_b;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_allowed = rsp_allowed_ff;

endmodule

@@ rtl/tlfc_checker.sv @@
// tlfc_checker: port-level assertions for the tabu list frequency check unit
// depends on nothing but the top level's ports; bound to tabu_list_frequency_check_unit

module tlfc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_operation,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        pready
);

   // one item at a time: no acceptance in the cycle after one
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("item accepted back to back");

   // a ban never produces a result
   a_ban_silent: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_operation && !rsp_valid) |=> !rsp_valid)
      else $error("result appeared after a ban item");

   // a new result comes from the merge step, never while idle
   a_result_from_merge: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result raised while input side was idle");

   // a stalled result stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result dropped while stalled");

   a_pready: assert property (@(posedge clock) disable iff (reset) pready)
      else $error("register port not ready");

endmodule

bind tabu_list_frequency_check_unit tlfc_checker u_tlfc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_operation (req_operation),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .pready        (pready)
);

@@ tb/tb.sv @@
// tb: self-checking testbench for tabu_list_frequency_check_unit, tabu bans and swap queries
// depends on tlfc_pkg and the rtl top level; a scoreboard class predicts every query verdict
`timescale 1ns / 100ps

module tb;

   localparam int WATCHDOG_LIMIT = 400000;
   localparam int SAT_BANS       = 8;
   localparam logic [31:0] PEN_EDGE = 32'(6000 + 65535 + (65535 * (2 * SAT_BANS + 1)) / 256);

   typedef struct packed {
      logic              op;
      logic [31:0]       iteration;
      logic signed [6:0] course_one;
      logic [3:0]        room_one;
      logic [2:0]        day_one;
      logic [2:0]        slot_one;
      logic signed [6:0] course_two;
      logic [3:0]        room_two;
      logic [2:0]        day_two;
      logic [2:0]        slot_two;
   } move_type;

   class tabu_verdict_board;
      bit [31:0]   ban_time [65536];
      bit [15:0]   ban_count [65536];
      logic [15:0] tenure;
      logic [15:0] coeff;
      bit          pending_verdicts [$];
      int          fails;

      function new();
         tenure = tlfc_pkg::TENURE_RESET;
         coeff  = tlfc_pkg::COEFF_RESET;
         fails  = 0;
      endfunction

      function void set_reg(logic idx, logic [15:0] v);
         if (idx == tlfc_pkg::REG_TENURE) begin
            tenure = v;
         end else begin
            coeff = v;
         end
      endfunction

      function bit half_clear(logic [6:0] course, logic [3:0] room, logic [2:0] day,
                              logic [2:0] slot, logic [31:0] now);
         logic [15:0] idx;
         logic [63:0] unban_at;
         if (course[6]) return 1'b1;
         idx = {course[5:0], room, day, slot};
         if (ban_count[idx] == 16'd0) return 1'b1;
         unban_at = 64'(ban_time[idx]) + 64'(tenure)
                  + ((64'(coeff) * 64'(ban_count[idx])) >> 8);
         return unban_at < 64'(now);
      endfunction

      function void stamp(logic [6:0] course, logic [3:0] room, logic [2:0] day,
                          logic [2:0] slot, logic [31:0] now);
         logic [15:0] idx;
         if (course[6]) return;
         idx = {course[5:0], room, day, slot};
         ban_time[idx] = now;
         if (ban_count[idx] != 16'hFFFF) ban_count[idx] = ban_count[idx] + 16'd1;
      endfunction

      function void note_move(move_type m);
         if (m.op == tlfc_pkg::OP_BAN) begin
            stamp(m.course_one, m.room_one, m.day_one, m.slot_one, m.iteration);
            stamp(m.course_two, m.room_two, m.day_two, m.slot_two, m.iteration);
         end else begin
            pending_verdicts.push_back(
               half_clear(m.course_one, m.room_two, m.day_two, m.slot_two, m.iteration) &&
               half_clear(m.course_two, m.room_one, m.day_one, m.slot_one, m.iteration));
         end
      endfunction

      function void check_verdict(logic got);
         bit want;
         if (pending_verdicts.size() == 0) begin
            $error("allowed: no query waiting, got %0b", got);
            fails++;
         end else begin
            want = pending_verdicts.pop_front();
            if (got !== want) begin
               $error("allowed: expected %0b, got %0b", want, got);
               fails++;
            end
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_operation = tlfc_pkg::OP_QUERY;
   logic [31:0]       req_iteration = '0;
   logic signed [6:0] req_course_one = '0;
   logic [3:0]        req_room_one = '0;
   logic [2:0]        req_day_one = '0;
   logic [2:0]        req_slot_one = '0;
   logic signed [6:0] req_course_two = '0;
   logic [3:0]        req_room_two = '0;
   logic [2:0]        req_day_two = '0;
   logic [2:0]        req_slot_two = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic              rsp_allowed;
   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [2:0]        paddr = '0;
   logic [31:0]       pwdata = '0;
   logic [31:0]       prdata;
   logic              pready;

   tabu_verdict_board board = new();
   bit                calm = 1'b0;
   int                rsp_hold = 0;
   int                quiet_cycles = 0;
   logic [31:0]       search_iter = '0;

   tabu_list_frequency_check_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_operation(req_operation), .req_iteration(req_iteration),
      .req_course_one(req_course_one), .req_room_one(req_room_one),
      .req_day_one(req_day_one), .req_slot_one(req_slot_one),
      .req_course_two(req_course_two), .req_room_two(req_room_two),
      .req_day_two(req_day_two), .req_slot_two(req_slot_two),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_allowed(rsp_allowed),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   always @(posedge clock) begin
      if (rsp_hold != 0) begin
         rsp_hold = rsp_hold - 1;
      end else begin
         rsp_hold = pick_gap();
         rsp_ready <= (rsp_hold == 0);
         if (rsp_hold != 0) rsp_hold = rsp_hold - 1;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            board.note_move({req_operation, req_iteration, req_course_one, req_room_one,
                             req_day_one, req_slot_one, req_course_two, req_room_two,
                             req_day_two, req_slot_two});
         end
         if (rsp_valid && rsp_ready) board.check_verdict(rsp_allowed);
      end
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles = quiet_cycles + 1;
      end
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic move_type move_of(logic op, logic [31:0] it,
                                        logic signed [6:0] c1, logic [3:0] r1, logic [2:0] d1,
                                        logic [2:0] s1, logic signed [6:0] c2, logic [3:0] r2,
                                        logic [2:0] d2, logic [2:0] s2);
      move_type m;
      m = {op, it, c1, r1, d1, s1, c2, r2, d2, s2};
      return m;
   endfunction

   task automatic offer_move(move_type m);
      int gap;
      req_operation  <= m.op;
      req_iteration  <= m.iteration;
      req_course_one <= m.course_one;
      req_room_one   <= m.room_one;
      req_day_one    <= m.day_one;
      req_slot_one   <= m.slot_one;
      req_course_two <= m.course_two;
      req_room_two   <= m.room_two;
      req_day_two    <= m.day_two;
      req_slot_two   <= m.slot_two;
      req_valid      <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic quiesce();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending_verdicts.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [15:0] v);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= {idx, 2'b00};
      pwdata  <= {16'h0000, v};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      board.set_reg(idx, v);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic signed [6:0] pick_course();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) return 7'($urandom_range(0, 3));
      if (r < 85) return -7'sd1;
      if (r < 90) return 7'($urandom_range(64, 127));
      return 7'($urandom_range(0, 63));
   endfunction

   function automatic int pick_place(int hi);
      if ($urandom_range(0, 99) < 80) return $urandom_range(0, 1);
      return $urandom_range(0, hi);
   endfunction

   function automatic move_type random_move(int stride);
      int r;
      logic op;
      r = $urandom_range(0, 99);
      if (r < 2) begin
         search_iter = $urandom;
      end else if (r < 4) begin
         search_iter = 32'hFFFF_FFFF - 32'($urandom_range(0, 200));
      end else begin
         search_iter = search_iter + 32'($urandom_range(0, stride));
      end
      op = ($urandom_range(0, 99) < 40) ? tlfc_pkg::OP_BAN : tlfc_pkg::OP_QUERY;
      return move_of(op, search_iter,
                     pick_course(), 4'(pick_place(15)), 3'(pick_place(7)), 3'(pick_place(7)),
                     pick_course(), 4'(pick_place(15)), 3'(pick_place(7)), 3'(pick_place(7)));
   endfunction

   initial begin
      logic [15:0] tenure_v;
      logic [15:0] coeff_v;
      int          stride;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values of the registers
      offer_move(move_of(tlfc_pkg::OP_QUERY, 32'd0, 7'sd0, 4'd0, 3'd0, 3'd0,
                         7'sd0, 4'd0, 3'd0, 3'd0));
      offer_move(move_of(tlfc_pkg::OP_BAN, 32'd1000, 7'sd5, 4'd3, 3'd2, 3'd1,
                         7'sd63, 4'd15, 3'd7, 3'd7));
      offer_move(move_of(tlfc_pkg::OP_QUERY, 32'd1120, 7'sd5, 4'd15, 3'd7, 3'd7,
                         7'sd63, 4'd3, 3'd2, 3'd1));
      offer_move(move_of(tlfc_pkg::OP_QUERY, 32'd1121, 7'sd5, 4'd15, 3'd7, 3'd7,
                         7'sd63, 4'd3, 3'd2, 3'd1));
      offer_move(move_of(tlfc_pkg::OP_QUERY, 32'd1050, 7'sd5, 4'd0, 3'd0, 3'd0,
                         -7'sd1, 4'd3, 3'd2, 3'd1));
      offer_move(move_of(tlfc_pkg::OP_QUERY, 32'd1050, -7'sd1, 4'd15, 3'd7, 3'd7,
                         -7'sd1, 4'd3, 3'd2, 3'd1));
      offer_move(move_of(tlfc_pkg::OP_BAN, 32'd2000, -7'sd1, 4'd0, 3'd0, 3'd0,
                         -7'sd64, 4'd0, 3'd0, 3'd0));
      offer_move(move_of(tlfc_pkg::OP_QUERY, 32'd2001, 7'sd0, 4'd0, 3'd0, 3'd0,
                         7'sd0, 4'd0, 3'd0, 3'd0));
      // same entry in both halves, stamped at the top of the time range
      offer_move(move_of(tlfc_pkg::OP_BAN, 32'hFFFF_FFFF, 7'sd20, 4'd0, 3'd0, 3'd0,
                         7'sd20, 4'd0, 3'd0, 3'd0));
      offer_move(move_of(tlfc_pkg::OP_QUERY, 32'hFFFF_FFFF, 7'sd20, 4'd9, 3'd4, 3'd5,
                         -7'sd64, 4'd0, 3'd0, 3'd0));
      offer_move(move_of(tlfc_pkg::OP_QUERY, 32'hFFFF_FFFF, 7'sd42, 4'd10, 3'd5, 3'd2,
                         7'sd20, 4'd0, 3'd0, 3'd0));
      quiesce();

      write_reg(tlfc_pkg::REG_TENURE, 16'd0);
      write_reg(tlfc_pkg::REG_COEFF, 16'd256);
      offer_move(move_of(tlfc_pkg::OP_BAN, 32'd10, 7'sd1, 4'd1, 3'd1, 3'd1,
                         7'sd2, 4'd2, 3'd2, 3'd2));
      offer_move(move_of(tlfc_pkg::OP_QUERY, 32'd11, 7'sd1, 4'd1, 3'd1, 3'd1,
                         7'sd2, 4'd2, 3'd2, 3'd2));
      offer_move(move_of(tlfc_pkg::OP_QUERY, 32'd12, 7'sd2, 4'd1, 3'd1, 3'd1,
                         7'sd1, 4'd2, 3'd2, 3'd2));
      offer_move(move_of(tlfc_pkg::OP_QUERY, 32'd12, 7'sd1, 4'd2, 3'd2, 3'd2,
                         7'sd2, 4'd1, 3'd1, 3'd1));
      quiesce();

      // repeated bans on one entry, then boundary queries with the largest tenure and coefficient
      write_reg(tlfc_pkg::REG_TENURE, 16'hFFFF);
      write_reg(tlfc_pkg::REG_COEFF, 16'hFFFF);
      calm = 1'b1;
      for (int i = 0; i < SAT_BANS; i++) begin
         offer_move(move_of(tlfc_pkg::OP_BAN, 32'd5000, 7'sd9, 4'd2, 3'd3, 3'd4,
                            7'sd9, 4'd2, 3'd3, 3'd4));
      end
      calm = 1'b0;
      offer_move(move_of(tlfc_pkg::OP_BAN, 32'd6000, 7'sd9, 4'd2, 3'd3, 3'd4,
                         -7'sd1, 4'd0, 3'd0, 3'd0));
      for (int k = -1; k <= 1; k++) begin
         offer_move(move_of(tlfc_pkg::OP_QUERY, PEN_EDGE + 32'(k),
                            7'sd9, 4'd0, 3'd0, 3'd0, -7'sd1, 4'd2, 3'd3, 3'd4));
         offer_move(move_of(tlfc_pkg::OP_QUERY, PEN_EDGE + 32'(k),
                            -7'sd1, 4'd2, 3'd3, 3'd4, 7'sd9, 4'd0, 3'd0, 3'd0));
      end
      quiesce();

      for (int p = 0; p < 5; p++) begin
         case (p)
            0: begin tenure_v = tlfc_pkg::TENURE_RESET; coeff_v = tlfc_pkg::COEFF_RESET; end
            1: begin tenure_v = 16'd0;     coeff_v = 16'hFFFF; end
            2: begin tenure_v = 16'hFFFF;  coeff_v = 16'd0;    end
            3: begin tenure_v = 16'd5;     coeff_v = 16'd384;  end
            default: begin
               tenure_v = 16'($urandom_range(0, 300));
               coeff_v  = 16'($urandom_range(0, 2048));
            end
         endcase
         write_reg(tlfc_pkg::REG_TENURE, tenure_v);
         write_reg(tlfc_pkg::REG_COEFF, coeff_v);
         stride = int'(tenure_v) / 8 + int'(coeff_v) / 64 + 6;
         for (int i = 0; i < 180; i++) begin
            if ($urandom_range(0, 39) == 0) calm = !calm;
            offer_move(random_move(stride));
         end
         calm = 1'b0;
         quiesce();
      end

      if (board.fails == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
